// ----- hw/rtl/deq_pkg.sv -----
// Shared types and sizing constants for the double-ended queue.
package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int WORD_W     = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CNT_OUT_W  = 11;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DATA = 2'd1,
        ST_ERR  = 2'd2
    } deq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } deq_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic capture;
    } deq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic needs_read;
    } deq_stat_t;

endpackage

// ----- hw/rtl/deq_cmd_if.sv -----
// Request channel carrying one queue command per transfer.
interface deq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ----- hw/rtl/deq_rsp_if.sv -----
// Response channel carrying one queue result per transfer.
interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data_word;
    logic [10:0]        count;

    modport source (output valid, output status, output data_word, output count, input ready);
    modport sink   (input valid, input status, input data_word, input count, output ready);
endinterface

// ----- hw/rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: controller, datapath and checks.
//
// Usage:
//   request  : valid/ready channel carrying command (3 bits) and value (32 bits).
//   response : valid/ready channel carrying status, data_word and count.
//   One response follows every request transfer, in order.
//   Push, size and clear: the response is valid the cycle after the transfer.
//   Successful pop and peek: the response passes through S_READ before S_RESP,
//   as the ring store has a registered read port.
//   One command is in flight at a time: the single-issue sequencer takes no
//   new request until the receiver has taken the response to the last one.
//   While the receiver stalls, the response holds and request.ready stays low.
//   Reset: pointers and count go to zero and no response is pending; the store
//   needs no clearing pass, so a request may follow the first clock edge.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    deq_cmd_if.sink   request,
    deq_rsp_if.source response
);

    deq_ctrl_t ctrl;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    deq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .command   (request.command),
        .value     (request.value),
        .status    (response.status),
        .data_word (response.data_word),
        .count     (response.count)
    );

    // never take a new command while a result is pending
    a_single_issue: assert property (@(posedge clk) disable iff (!rst_n)
        !(response.valid && request.ready))
        else $error("request taken while a response is pending");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request ready straight after a transfer");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status != ST_DATA)) |-> (response.data_word == '0))
        else $error("data word not zero on a result without data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (response.status != 2'd3))
        else $error("undefined status code");

endmodule

// ----- hw/rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/deq_ctrl.sv -----
// Sequencer for the queue: accept, optional store read, response hand-off.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  deq_stat_t stat,
    output deq_ctrl_t ctrl
);

    deq_state_t state_reg;
    deq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.needs_read ? S_READ : S_RESP;
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        ctrl.capture = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready     = 1'b1;
            S_READ:  ctrl.capture = 1'b1;
            S_RESP:  out_valid    = 1'b1;
            default: in_ready     = 1'b0;
        endcase
        ctrl.exec = in_ready && in_valid;
    end

endmodule

// ----- hw/rtl/deq_datapath.sv -----
// Ring pointers, word count, result registers and the ring store.
module deq_datapath
    import deq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_ctrl_t             ctrl,
    output deq_stat_t             stat,
    input  logic [2:0]            command,
    input  logic signed [31:0]    value,
    output logic [1:0]            status,
    output logic signed [31:0]    data_word,
    output logic [CNT_OUT_W-1:0]  count
);

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    deq_status_t       status_reg, status_next;
    logic [WORD_W-1:0] data_reg;

    logic [PTR_W-1:0]  head_up, head_dn, tail_up, tail_dn;
    logic              full, empty;
    deq_op_t           op;

    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign op    = deq_op_t'(command);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign head_up = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dn = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_up = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dn = (tail_reg == '0) ? PTR_W'(DEPTH - 1) : tail_reg - 1'b1;

    always_comb
    begin
        stat.needs_read = !empty &&
            (op inside {OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK});
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = tail_reg;
        ram_raddr   = head_reg;
        case (op)
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_ERR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    tail_next  = tail_up;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_FRONT:
            begin
                ram_waddr = head_dn;
                if (full)
                begin
                    status_next = ST_ERR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    head_next  = head_dn;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_ERR;
                end
                else
                begin
                    status_next = ST_DATA;
                    ram_re      = 1'b1;
                    if (op == OP_POP_FRONT)
                    begin
                        head_next  = head_up;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK:
            begin
                ram_raddr = tail_dn;
                if (empty)
                begin
                    status_next = ST_ERR;
                end
                else
                begin
                    status_next = ST_DATA;
                    ram_re      = 1'b1;
                    if (op == OP_POP_BACK)
                    begin
                        tail_next  = tail_dn;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            OP_SIZE:
            begin
                status_next = ST_OK;
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // zero the data word on every transfer, load it once the store read lands
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg <= status_next;
            data_reg   <= '0;
        end
        else if (ctrl.capture)
        begin
            data_reg <= ram_rdata;
        end
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.exec && ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ctrl.exec && ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status    = status_reg;
    assign data_word = data_reg;
    assign count     = CNT_OUT_W'(count_reg);

endmodule

// ----- tb/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue, with a shadow deque as predictor.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        deq_status_t            status;
        logic [WORD_W-1:0]      data_word;
        logic [CNT_OUT_W-1:0]   count;
    } deq_result_t;

    logic clk;
    logic rst_n;

    deq_cmd_if req_if ();
    deq_rsp_if rsp_if ();

    double_ended_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    // shadow deque
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                head_idx  = 0;
    int                tail_idx  = 0;
    int                occupancy = 0;

    deq_result_t awaited_results [$];

    bit idle_on       = 1'b1;
    int mismatches    = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_empty_err   = 0;
    int n_full_err    = 0;
    int peak_fill     = 0;
    int stall_cycles  = 0;

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int ring_next(input int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int ring_prev(input int p);
        return (p == 0) ? DEPTH - 1 : p - 1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Apply one command to the shadow deque and return the response it must give.
    function automatic deq_result_t predict_deq_result(input deq_op_t op,
                                                       input logic [WORD_W-1:0] val);
        deq_result_t r;
        int          slot;
        r.status    = ST_OK;
        r.data_word = '0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (occupancy >= DEPTH)
                begin
                    r.status = ST_ERR;
                    n_full_err++;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    shadow_words[tail_idx] = val;
                    tail_idx = ring_next(tail_idx);
                    occupancy++;
                end
                else
                begin
                    head_idx = ring_prev(head_idx);
                    shadow_words[head_idx] = val;
                    occupancy++;
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK:
            begin
                if (occupancy == 0)
                begin
                    r.status = ST_ERR;
                    n_empty_err++;
                end
                else
                begin
                    slot = (op == OP_POP_FRONT || op == OP_PEEK_FRONT) ? head_idx
                                                                       : ring_prev(tail_idx);
                    r.status    = ST_DATA;
                    r.data_word = shadow_words[slot];
                    if (op == OP_POP_FRONT)
                    begin
                        head_idx = ring_next(head_idx);
                        occupancy--;
                    end
                    else if (op == OP_POP_BACK)
                    begin
                        tail_idx = slot;
                        occupancy--;
                    end
                end
            end
            OP_SIZE:
            begin
            end
            default:
            begin
                head_idx  = 0;
                tail_idx  = 0;
                occupancy = 0;
            end
        endcase
        if (occupancy > peak_fill)
            peak_fill = occupancy;
        r.count = CNT_OUT_W'(occupancy);
        return r;
    endfunction

    // Returns at the edge of the transfer; valid is left high so that a following
    // call in the same step can present its command back to back.
    task automatic send_cmd(input deq_op_t op, input logic [WORD_W-1:0] val);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= op;
        req_if.value   <= val;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        awaited_results.insert(awaited_results.size(), predict_deq_result(op, val));
        n_sent++;
    endtask

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Empty-queue errors, every operation, field extremes and pointer wrap both ways.
    task automatic test_directed();
        send_cmd(OP_POP_FRONT,  pick_word());
        send_cmd(OP_POP_BACK,   pick_word());
        send_cmd(OP_PEEK_FRONT, pick_word());
        send_cmd(OP_PEEK_BACK,  pick_word());
        send_cmd(OP_SIZE,       32'hFFFF_FFFF);
        send_cmd(OP_PUSH_FRONT, 32'h8000_0000);
        send_cmd(OP_PUSH_BACK,  32'h7FFF_FFFF);
        send_cmd(OP_PUSH_BACK,  32'h0000_0000);
        send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_cmd(OP_PEEK_FRONT, 32'h0000_0000);
        send_cmd(OP_PEEK_BACK,  32'hFFFF_FFFF);
        send_cmd(OP_SIZE,       32'h0000_0000);
        send_cmd(OP_POP_BACK,   pick_word());
        send_cmd(OP_POP_FRONT,  pick_word());
        send_cmd(OP_POP_FRONT,  pick_word());
        send_cmd(OP_POP_BACK,   pick_word());
        send_cmd(OP_PUSH_BACK,  32'h5555_5555);
        send_cmd(OP_PUSH_BACK,  32'hAAAA_AAAA);
        send_cmd(OP_CLEAR,      pick_word());
        send_cmd(OP_PEEK_FRONT, pick_word());
        // from cleared pointers: head wraps down, tail wraps down then up, head up
        send_cmd(OP_PUSH_FRONT, 32'h0000_0001);
        send_cmd(OP_POP_BACK,   pick_word());
        send_cmd(OP_PUSH_BACK,  32'hFFFF_FFFE);
        send_cmd(OP_POP_FRONT,  pick_word());
        send_cmd(OP_SIZE,       pick_word());
    endtask

    // Random commands with a fill level kept low, so empty errors come up often.
    task automatic test_random_mix(input int n_items);
        deq_op_t op;
        int      r;
        int      push_pct;
        bit      coin;
        for (int i = 0; i < n_items; i++)
        begin
            idle_on  = (i < n_items / 3) || (i >= 2 * n_items / 3);
            push_pct = (occupancy < 4) ? 50 : ((occupancy > 12) ? 25 : 38);
            r        = $urandom_range(0, 99);
            coin     = 1'($urandom_range(0, 1));
            if (r < push_pct)
                op = coin ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else if (r < push_pct + 32)
                op = coin ? OP_POP_FRONT : OP_POP_BACK;
            else if (r < 90)
                op = coin ? OP_PEEK_FRONT : OP_PEEK_BACK;
            else if (r < 98)
                op = OP_SIZE;
            else
                op = OP_CLEAR;
            send_cmd(op, pick_word());
        end
        idle_on = 1'b1;
    endtask

    // Fill to capacity from wherever the pointers stand, then push into a full queue.
    task automatic test_fill_to_full();
        while (occupancy < DEPTH)
            send_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        send_cmd(OP_PUSH_BACK,  pick_word());
        send_cmd(OP_PUSH_FRONT, pick_word());
        send_cmd(OP_PEEK_FRONT, pick_word());
        send_cmd(OP_PEEK_BACK,  pick_word());
        send_cmd(OP_SIZE,       pick_word());
    endtask

    // Hover near the full boundary: pops leave it, pushes return to it or hit a full queue.
    task automatic test_churn_at_full(input int n_items);
        deq_op_t op;
        int      r;
        bit      coin;
        for (int i = 0; i < n_items; i++)
        begin
            idle_on = (i >= n_items / 2);
            r       = $urandom_range(0, 99);
            coin    = 1'($urandom_range(0, 1));
            if (occupancy == DEPTH)
                op = (r < 40) ? (coin ? OP_PUSH_FRONT : OP_PUSH_BACK)
                   : (r < 75) ? (coin ? OP_POP_FRONT : OP_POP_BACK)
                   : (coin ? OP_PEEK_FRONT : OP_PEEK_BACK);
            else
                op = (r < 70) ? (coin ? OP_PUSH_FRONT : OP_PUSH_BACK)
                   : (coin ? OP_POP_FRONT : OP_POP_BACK);
            send_cmd(op, pick_word());
        end
        send_cmd(OP_CLEAR, pick_word());
        send_cmd(OP_SIZE,  pick_word());
        idle_on = 1'b1;
    endtask

    initial
    begin : sink_ready
        int hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        deq_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
                log_mismatch("response with nothing pending", '0, rsp_if.data_word);
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                n_checked++;
                if (rsp_if.status !== want.status)
                    log_mismatch("status", 32'(want.status), 32'(rsp_if.status));
                if (rsp_if.data_word !== want.data_word)
                    log_mismatch("data_word", want.data_word, rsp_if.data_word);
                if (rsp_if.count !== want.count)
                    log_mismatch("count", 32'(want.count), 32'(rsp_if.count));
            end
        end
    end

    // Give up when no transfer happens on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles, %0d responses outstanding",
                     $realtime, STALL_LIMIT, awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : run_tests
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.command <= OP_SIZE;
        req_if.value   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(450);
        test_fill_to_full();
        test_churn_at_full(150);

        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        // catch any stray response after the last one
        repeat (6) @(posedge clk);

        $display("Checked %0d responses to %0d commands, peak fill %0d of %0d words.",
                 n_checked, n_sent, peak_fill, DEPTH);
        $display("Errors provoked: %0d on an empty queue, %0d on a full one; %0d mismatches.",
                 n_empty_err, n_full_err, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
